// ----- hw/rtl/command_retransmit_tracker_core_defines.svh -----
// assertion macros for the retransmit tracker
// used only by the top level; no other dependencies
`ifndef COMMAND_RETRANSMIT_TRACKER_CORE_DEFINES_SVH
`define COMMAND_RETRANSMIT_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTH
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CRT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CRT_ASSERT(lbl, prop, msg)
`define CRT_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/crt_pkg.sv -----
// types, codes and helper functions of the retransmit tracker
// no dependencies
package crt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic [12:0] RespTimeRst  = 13'd20;
  localparam logic [15:0] MaxTimeRst   = 16'd5000;
  localparam logic [3:0]  MaxRetryRst  = 4'd3;
  localparam logic [7:0]  FlowEnRst    = 8'd1;
  localparam logic [7:0]  FlowDisRst   = 8'd2;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_RESP  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_CLEAN = 2'd3
  } crt_func_e;

  typedef enum logic [3:0] {
    KIND_UNTRACKED  = 4'd0,
    KIND_TRACKED    = 4'd1,
    KIND_FULL       = 4'd2,
    KIND_MATCHED    = 4'd3,
    KIND_UNMATCHED  = 4'd4,
    KIND_RETRANSMIT = 4'd5,
    KIND_DROPPED    = 4'd6,
    KIND_CLEANED    = 4'd7,
    KIND_SUPERSEDED = 4'd8,
    KIND_IDLE       = 4'd9
  } crt_kind_e;

  typedef enum logic [2:0] {
    REG_RESP_TIME = 3'd0,
    REG_MAX_TIME  = 3'd1,
    REG_MAX_RETRY = 3'd2,
    REG_FLOW_EN   = 3'd3,
    REG_FLOW_DIS  = 3'd4
  } crt_reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  port_id;
    logic [15:0] stream_num;
    logic [7:0]  cmd_code;
    logic [7:0]  ip_fam;
    logic [15:0] seq_num;
    logic [31:0] qos_id;
    logic [31:0] tx_id;
    logic        length_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_kind;
    logic [7:0]  out_port;
    logic [15:0] out_stream;
    logic [7:0]  out_cmd;
    logic [7:0]  out_ip_fam;
    logic [15:0] out_seq;
    logic [31:0] out_qos;
    logic [31:0] out_tx_id;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [12:0] response_time_ms;
    logic [15:0] max_timeout_ms;
    logic [3:0]  max_retries;
    logic [7:0]  flow_enable_code;
    logic [7:0]  flow_disable_code;
  } crt_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  port;
    logic [15:0] stream;
    logic [7:0]  cmd;
    logic [7:0]  ip;
    logic [15:0] seq;
    logic [31:0] qos;
    logic [31:0] txid;
    logic [3:0]  retry;
    logic [15:0] timeout;
    logic [15:0] remaining;
  } crt_entry_t;

  function automatic logic is_flow(logic [7:0] code, crt_cfg_t cfg);
    return (code == cfg.flow_enable_code) || (code == cfg.flow_disable_code);
  endfunction

  function automatic logic same_key(crt_entry_t e, logic [15:0] stream, logic [7:0] ip,
                                    logic [31:0] qos, crt_cfg_t cfg);
    return e.valid && (e.stream == stream) && (e.ip == ip) && (e.qos == qos) &&
           is_flow(e.cmd, cfg);
  endfunction

  function automatic logic [15:0] cap_time(logic [16:0] t, logic [15:0] max_t);
    return (t > {1'b0, max_t}) ? max_t : t[15:0];
  endfunction

  function automatic out_item_t res_of_entry(crt_kind_e kind, crt_entry_t e);
    out_item_t r;
    r.out_kind    = kind;
    r.out_port    = e.port;
    r.out_stream  = e.stream;
    r.out_cmd     = e.cmd;
    r.out_ip_fam  = e.ip;
    r.out_seq     = e.seq;
    r.out_qos     = e.qos;
    r.out_tx_id   = e.txid;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic out_item_t res_of_input(crt_kind_e kind, in_item_t x, logic keep_port);
    out_item_t r;
    r.out_kind    = kind;
    r.out_port    = keep_port ? x.port_id : 8'd0;
    r.out_stream  = x.stream_num;
    r.out_cmd     = x.cmd_code;
    r.out_ip_fam  = x.ip_fam;
    r.out_seq     = x.seq_num;
    r.out_qos     = x.qos_id;
    r.out_tx_id   = x.tx_id;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/command_retransmit_tracker_core.sv -----
// Send, response, clean: ring alignment (S_SEEK), a scan of all TableDepth entries (S_SCAN),
// then S_FIN and, if it pushes a result, S_FLUSH; an untracked send skips the scan.
// Tick: alignment, a pass over every entry (S_TOUT), a full sweep (S_TSEEK, S_TIN) per
// retransmitted entry kept, S_FIN as above. One item at a time; results one a cycle at most.
// Reset clears all entry valid bits and loads the register defaults; no clearing pass.
// Results cannot be stalled by the receiver; the last one of an item has last_result set.
`include "command_retransmit_tracker_core_defines.svh"
module command_retransmit_tracker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  crt_pkg::in_item_t  item_i,
  output logic               out_valid_o,
  output crt_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int Depth = crt_pkg::TableDepth;

  crt_pkg::crt_cfg_t   cfg_q, cfg_d;
  crt_pkg::crt_entry_t ring[Depth];
  crt_pkg::crt_entry_t wb;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crt_pkg::REG_RESP_TIME: cfg_d.response_time_ms  = cfg_data_i[12:0];
        crt_pkg::REG_MAX_TIME:  cfg_d.max_timeout_ms    = cfg_data_i;
        crt_pkg::REG_MAX_RETRY: cfg_d.max_retries       = cfg_data_i[3:0];
        crt_pkg::REG_FLOW_EN:   cfg_d.flow_enable_code  = cfg_data_i[7:0];
        crt_pkg::REG_FLOW_DIS:  cfg_d.flow_disable_code = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_time_ms  <= crt_pkg::RespTimeRst;
      cfg_q.max_timeout_ms    <= crt_pkg::MaxTimeRst;
      cfg_q.max_retries       <= crt_pkg::MaxRetryRst;
      cfg_q.flow_enable_code  <= crt_pkg::FlowEnRst;
      cfg_q.flow_disable_code <= crt_pkg::FlowDisRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // entries rotate toward the head; the head entry comes back at the tail
  for (genvar k = 0; k < Depth; k++) begin : g_ring
    if (k == Depth - 1) begin : g_tail
      crt_cell u_cell (.clk_i, .rst_ni, .ent_i(wb), .ent_o(ring[k]));
    end else begin : g_mid
      crt_cell u_cell (.clk_i, .rst_ni, .ent_i(ring[k+1]), .ent_o(ring[k]));
    end
  end

  crt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .start_i     (start && !busy),
    .item_i,
    .busy_o      (busy),
    .head_i      (ring[0]),
    .wb_o        (wb),
    .out_valid_o,
    .result_o
  );

  `CRT_ASSERT(a_out_only_busy, out_valid_o |-> busy, "result transfer while not busy")
  `CRT_ASSERT(a_last_ends, out_valid_o && result_o.last_result |=> !busy,
              "block still busy after last result")
  `CRT_ASSERT(a_start_busy, start && !busy |=> busy, "accepted item did not start work")
  `CRT_ASSERT_NR(a_reset_quiet, !rst_ni |-> !out_valid_o, "result transfer during reset")

endmodule

// ----- hw/rtl/crt_cell.sv -----
// one table entry of the ring; takes its neighbor's entry every cycle
// depends on crt_pkg
module crt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crt_pkg::crt_entry_t ent_i,
  output crt_pkg::crt_entry_t ent_o
);

  logic                valid_q;
  crt_pkg::crt_entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= ent_i;
  end

  always_comb begin
    ent_o       = data_q;
    ent_o.valid = valid_q;
  end

endmodule

// ----- hw/rtl/crt_ctrl.sv -----
// sequencer working on the entry at the head of the ring, with result holdback
// depends on crt_pkg
module crt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crt_pkg::crt_cfg_t     cfg_i,
  input  logic                  start_i,
  input  crt_pkg::in_item_t     item_i,
  output logic                  busy_o,
  input  crt_pkg::crt_entry_t   head_i,
  output crt_pkg::crt_entry_t   wb_o,
  output logic                  out_valid_o,
  output crt_pkg::out_item_t    result_o
);

  localparam int IdxW = crt_pkg::IdxW;
  localparam int Depth = crt_pkg::TableDepth;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEEK  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_TOUT  = 8'b0000_1000,
    S_TSEEK = 8'b0001_0000,
    S_TIN   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     hidx_q, hidx_d;
  logic [IdxW:0]       oi_q, oi_d;
  logic [IdxW-1:0]     ki_q, ki_d;
  logic [15:0]         kstream_q, kstream_d;
  logic [7:0]          kip_q, kip_d;
  logic [31:0]         kqos_q, kqos_d;
  logic [Depth-1:0]    rep_q, rep_d;
  logic                found_q, found_d;
  crt_pkg::in_item_t   in_q, in_d;
  crt_pkg::out_item_t  pend_q, pend_d;
  logic                pend_v_q, pend_v_d;

  logic                push, emit_last, at_last, scan_act, tin_act, untracked, resp_ok;
  crt_pkg::out_item_t  push_res;
  logic [15:0]         new_t;
  crt_pkg::crt_entry_t ins;

  assign at_last   = (hidx_q == IdxW'(Depth - 1));
  assign scan_act  = (state_q == S_SCAN) || ((state_q == S_SEEK) && (hidx_q == '0));
  assign tin_act   = (state_q == S_TIN) || ((state_q == S_TSEEK) && (hidx_q == '0));
  assign untracked = !crt_pkg::is_flow(in_q.cmd_code, cfg_i) || (cfg_i.response_time_ms == '0);
  assign resp_ok   = crt_pkg::is_flow(in_q.cmd_code, cfg_i) && in_q.length_ok;
  assign new_t     = crt_pkg::cap_time({4'd0, cfg_i.response_time_ms}, cfg_i.max_timeout_ms);

  always_comb begin
    ins.valid     = 1'b1;
    ins.port      = in_q.port_id;
    ins.stream    = in_q.stream_num;
    ins.cmd       = in_q.cmd_code;
    ins.ip        = in_q.ip_fam;
    ins.seq       = in_q.seq_num;
    ins.qos       = in_q.qos_id;
    ins.txid      = in_q.tx_id;
    ins.retry     = '0;
    ins.timeout   = new_t;
    ins.remaining = new_t;
  end

  always_comb begin
    state_d   = state_q;
    hidx_d    = at_last ? '0 : hidx_q + 1'b1;
    oi_d      = oi_q;
    ki_d      = ki_q;
    kstream_d = kstream_q;
    kip_d     = kip_q;
    kqos_d    = kqos_q;
    rep_d     = rep_q;
    found_d   = found_q;
    in_d      = in_q;
    wb_o      = head_i;
    push      = 1'b0;
    push_res  = '0;
    emit_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          in_d    = item_i;
          found_d = 1'b0;
          rep_d   = '0;
          oi_d    = '0;
          if (item_i.func == crt_pkg::FUNC_TICK) begin
            state_d = S_TOUT;
          end else begin
            state_d = S_SEEK;
          end
        end
      end
      S_SEEK, S_SCAN: begin
        if (in_q.func == crt_pkg::FUNC_SEND && untracked) begin
          state_d = S_FIN;
        end else if (scan_act) begin
          state_d = at_last ? S_FIN : S_SCAN;
          case (in_q.func)
            crt_pkg::FUNC_SEND: begin
              if (crt_pkg::same_key(head_i, in_q.stream_num, in_q.ip_fam, in_q.qos_id,
                                    cfg_i)) begin
                push       = 1'b1;
                push_res   = crt_pkg::res_of_entry(crt_pkg::KIND_SUPERSEDED, head_i);
                wb_o.valid = 1'b0;
              end
              if (!wb_o.valid && !found_q) begin
                wb_o    = ins;
                found_d = 1'b1;
              end
            end
            crt_pkg::FUNC_RESP: begin
              if (resp_ok && !found_q && head_i.valid && head_i.txid == in_q.tx_id &&
                  head_i.stream == in_q.stream_num && head_i.cmd == in_q.cmd_code &&
                  head_i.ip == in_q.ip_fam && head_i.seq == in_q.seq_num &&
                  head_i.qos == in_q.qos_id) begin
                push       = 1'b1;
                push_res   = crt_pkg::res_of_entry(crt_pkg::KIND_MATCHED, head_i);
                wb_o.valid = 1'b0;
                found_d    = 1'b1;
              end
            end
            default: begin
              if (head_i.valid && head_i.port == in_q.port_id) begin
                push       = 1'b1;
                push_res   = crt_pkg::res_of_entry(crt_pkg::KIND_CLEANED, head_i);
                wb_o.valid = 1'b0;
              end
            end
          endcase
        end
      end
      S_TOUT: begin
        if (oi_q == (IdxW+1)'(Depth)) begin
          state_d = S_FIN;
        end else if (hidx_q == oi_q[IdxW-1:0]) begin
          oi_d = oi_q + 1'b1;
          if (head_i.valid) begin
            if (head_i.remaining > 16'd1) begin
              wb_o.remaining = head_i.remaining - 16'd1;
            end else begin
              rep_d[hidx_q] = 1'b1;
              push          = 1'b1;
              if (head_i.retry >= cfg_i.max_retries) begin
                push_res   = crt_pkg::res_of_entry(crt_pkg::KIND_DROPPED, head_i);
                wb_o.valid = 1'b0;
              end else begin
                push_res   = crt_pkg::res_of_entry(crt_pkg::KIND_RETRANSMIT, head_i);
                wb_o.retry = head_i.retry + 4'd1;
                if (cfg_i.response_time_ms == '0 || !crt_pkg::is_flow(head_i.cmd, cfg_i)) begin
                  wb_o.valid = 1'b0;
                end else begin
                  wb_o.timeout   = crt_pkg::cap_time({head_i.timeout, 1'b0},
                                                     cfg_i.max_timeout_ms);
                  wb_o.remaining = wb_o.timeout;
                  // sweep the whole table for entries of the same key
                  ki_d      = hidx_q;
                  kstream_d = head_i.stream;
                  kip_d     = head_i.ip;
                  kqos_d    = head_i.qos;
                  state_d   = S_TSEEK;
                end
              end
            end
          end
        end
      end
      S_TSEEK, S_TIN: begin
        if (tin_act) begin
          state_d = at_last ? S_TOUT : S_TIN;
          if (hidx_q != ki_q &&
              crt_pkg::same_key(head_i, kstream_q, kip_q, kqos_q, cfg_i)) begin
            if (!rep_q[hidx_q]) begin
              push     = 1'b1;
              push_res = crt_pkg::res_of_entry(crt_pkg::KIND_SUPERSEDED, head_i);
            end
            rep_d[hidx_q] = 1'b1;
            wb_o.valid    = 1'b0;
          end
        end
      end
      S_FIN: begin
        case (in_q.func)
          crt_pkg::FUNC_SEND: begin
            push     = 1'b1;
            push_res = crt_pkg::res_of_input(untracked ? crt_pkg::KIND_UNTRACKED :
                                             found_q ? crt_pkg::KIND_TRACKED :
                                             crt_pkg::KIND_FULL, in_q, 1'b1);
          end
          crt_pkg::FUNC_RESP: begin
            if (!found_q) begin
              push     = 1'b1;
              push_res = crt_pkg::res_of_input(crt_pkg::KIND_UNMATCHED, in_q, 1'b0);
            end
          end
          default: begin
            if (!pend_v_q) begin
              push              = 1'b1;
              push_res          = '0;
              push_res.out_kind = crt_pkg::KIND_IDLE;
            end
          end
        endcase
        if (push) begin
          state_d = S_FLUSH;
        end else begin
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FLUSH: begin
        emit_last = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // one result held back so that the final transfer can carry last_result
  always_comb begin
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_valid_o = 1'b0;
    if (push) begin
      out_valid_o = pend_v_q;
      pend_d      = push_res;
      pend_v_d    = 1'b1;
    end
    if (emit_last) begin
      out_valid_o = 1'b1;
      pend_v_d    = 1'b0;
    end
    result_o             = pend_q;
    result_o.last_result = emit_last;
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hidx_q   <= '0;
      oi_q     <= '0;
      rep_q    <= '0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      ki_q     <= '0;
    end else begin
      state_q  <= state_d;
      hidx_q   <= hidx_d;
      oi_q     <= oi_d;
      rep_q    <= rep_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      ki_q     <= ki_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    pend_q    <= pend_d;
    kstream_q <= kstream_d;
    kip_q     <= kip_d;
    kqos_q    <= kqos_d;
  end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for command_retransmit_tracker_core
// depends on crt_pkg and the tracker top level only
module tb_top;

  class tracker_scoreboard;
    crt_pkg::crt_entry_t tbl[crt_pkg::TableDepth];
    crt_pkg::crt_cfg_t   cfg;
    crt_pkg::out_item_t  pending[$];
    int                  errors;

    function new();
      cfg.response_time_ms  = crt_pkg::RespTimeRst;
      cfg.max_timeout_ms    = crt_pkg::MaxTimeRst;
      cfg.max_retries       = crt_pkg::MaxRetryRst;
      cfg.flow_enable_code  = crt_pkg::FlowEnRst;
      cfg.flow_disable_code = crt_pkg::FlowDisRst;
      foreach (tbl[i]) tbl[i] = '0;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void set_reg(crt_pkg::crt_reg_e idx, logic [15:0] v);
      case (idx)
        crt_pkg::REG_RESP_TIME: cfg.response_time_ms  = v[12:0];
        crt_pkg::REG_MAX_TIME:  cfg.max_timeout_ms    = v;
        crt_pkg::REG_MAX_RETRY: cfg.max_retries       = v[3:0];
        crt_pkg::REG_FLOW_EN:   cfg.flow_enable_code  = v[7:0];
        crt_pkg::REG_FLOW_DIS:  cfg.flow_disable_code = v[7:0];
        default: ;
      endcase
    endfunction

    function bit flow_code(logic [7:0] c);
      return c == cfg.flow_enable_code || c == cfg.flow_disable_code;
    endfunction

    function bit key_hit(int i, logic [15:0] s, logic [7:0] ip, logic [31:0] q);
      return tbl[i].valid && tbl[i].stream == s && tbl[i].ip == ip && tbl[i].qos == q &&
             flow_code(tbl[i].cmd);
    endfunction

    function crt_pkg::out_item_t from_entry(crt_pkg::crt_kind_e k, int i);
      crt_pkg::out_item_t r;
      r = '{k, tbl[i].port, tbl[i].stream, tbl[i].cmd, tbl[i].ip, tbl[i].seq,
            tbl[i].qos, tbl[i].txid, 1'b0};
      return r;
    endfunction

    function crt_pkg::out_item_t from_item(crt_pkg::crt_kind_e k, crt_pkg::in_item_t x,
                                           logic [7:0] p);
      crt_pkg::out_item_t r;
      r = '{k, p, x.stream_num, x.cmd_code, x.ip_fam, x.seq_num, x.qos_id, x.tx_id, 1'b0};
      return r;
    endfunction

    // works out every result of one accepted item and updates the table copy
    function void note_item(crt_pkg::in_item_t x);
      crt_pkg::out_item_t res[$];
      bit                 seen[crt_pkg::TableDepth];
      int                 slot, hit;
      int unsigned        t;
      crt_pkg::crt_func_e f;
      f = crt_pkg::crt_func_e'(x.func);
      case (f)
        crt_pkg::FUNC_SEND: begin
          if (!flow_code(x.cmd_code) || cfg.response_time_ms == 0) begin
            res.push_back(from_item(crt_pkg::KIND_UNTRACKED, x, x.port_id));
          end else begin
            slot = -1;
            for (int i = 0; i < crt_pkg::TableDepth; i++) begin
              if (key_hit(i, x.stream_num, x.ip_fam, x.qos_id)) begin
                res.push_back(from_entry(crt_pkg::KIND_SUPERSEDED, i));
                tbl[i].valid = 1'b0;
              end
            end
            for (int i = 0; i < crt_pkg::TableDepth; i++) begin
              if (slot < 0 && !tbl[i].valid) slot = i;
            end
            if (slot < 0) begin
              res.push_back(from_item(crt_pkg::KIND_FULL, x, x.port_id));
            end else begin
              t = cfg.response_time_ms;
              if (t > cfg.max_timeout_ms) t = cfg.max_timeout_ms;
              tbl[slot] = '{1'b1, x.port_id, x.stream_num, x.cmd_code, x.ip_fam,
                            x.seq_num, x.qos_id, x.tx_id, 4'd0, t[15:0], t[15:0]};
              res.push_back(from_item(crt_pkg::KIND_TRACKED, x, x.port_id));
            end
          end
        end
        crt_pkg::FUNC_RESP: begin
          hit = -1;
          if (flow_code(x.cmd_code) && x.length_ok) begin
            for (int i = 0; i < crt_pkg::TableDepth; i++) begin
              if (hit < 0 && tbl[i].valid && tbl[i].txid == x.tx_id &&
                  tbl[i].stream == x.stream_num && tbl[i].cmd == x.cmd_code &&
                  tbl[i].ip == x.ip_fam && tbl[i].seq == x.seq_num &&
                  tbl[i].qos == x.qos_id)
                hit = i;
            end
          end
          if (hit >= 0) begin
            res.push_back(from_entry(crt_pkg::KIND_MATCHED, hit));
            tbl[hit].valid = 1'b0;
          end else begin
            res.push_back(from_item(crt_pkg::KIND_UNMATCHED, x, 8'd0));
          end
        end
        crt_pkg::FUNC_TICK: begin
          foreach (seen[i]) seen[i] = 1'b0;
          for (int i = 0; i < crt_pkg::TableDepth; i++) begin
            if (!tbl[i].valid) continue;
            if (tbl[i].remaining > 1) begin
              tbl[i].remaining--;
              continue;
            end
            seen[i] = 1'b1;
            if (tbl[i].retry >= cfg.max_retries) begin
              res.push_back(from_entry(crt_pkg::KIND_DROPPED, i));
              tbl[i].valid = 1'b0;
              continue;
            end
            tbl[i].retry++;
            res.push_back(from_entry(crt_pkg::KIND_RETRANSMIT, i));
            if (cfg.response_time_ms == 0 || !flow_code(tbl[i].cmd)) begin
              tbl[i].valid = 1'b0;
              continue;
            end
            t = tbl[i].timeout * 2;
            if (t > cfg.max_timeout_ms) t = cfg.max_timeout_ms;
            tbl[i].timeout   = t[15:0];
            tbl[i].remaining = t[15:0];
            for (int j = 0; j < crt_pkg::TableDepth; j++) begin
              if (j != i && key_hit(j, tbl[i].stream, tbl[i].ip, tbl[i].qos)) begin
                if (!seen[j]) begin
                  res.push_back(from_entry(crt_pkg::KIND_SUPERSEDED, j));
                  seen[j] = 1'b1;
                end
                tbl[j].valid = 1'b0;
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < crt_pkg::TableDepth; i++) begin
            if (tbl[i].valid && tbl[i].port == x.port_id) begin
              res.push_back(from_entry(crt_pkg::KIND_CLEANED, i));
              tbl[i].valid = 1'b0;
            end
          end
        end
      endcase
      if (res.size() == 0) res.push_back('{crt_pkg::KIND_IDLE, 8'd0, 16'd0, 8'd0, 8'd0,
                                           16'd0, 32'd0, 32'd0, 1'b0});
      res[res.size()-1].last_result = 1'b1;
      foreach (res[i]) pending.push_back(res[i]);
    endfunction

    task check(crt_pkg::out_item_t got);
      crt_pkg::out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected result kind", got.out_kind, 0);
        return;
      end
      w = pending.pop_front();
      if (got.out_kind !== w.out_kind) report("kind", got.out_kind, w.out_kind);
      if (got.out_port !== w.out_port) report("port", got.out_port, w.out_port);
      if (got.out_stream !== w.out_stream) report("stream", got.out_stream, w.out_stream);
      if (got.out_cmd !== w.out_cmd) report("cmd", got.out_cmd, w.out_cmd);
      if (got.out_ip_fam !== w.out_ip_fam) report("ip", got.out_ip_fam, w.out_ip_fam);
      if (got.out_seq !== w.out_seq) report("seq", got.out_seq, w.out_seq);
      if (got.out_qos !== w.out_qos) report("qos", got.out_qos, w.out_qos);
      if (got.out_tx_id !== w.out_tx_id) report("tx_id", got.out_tx_id, w.out_tx_id);
      if (got.last_result !== w.last_result) report("last", got.last_result, w.last_result);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  crt_pkg::in_item_t  item_i = '0;
  logic               out_valid_o;
  crt_pkg::out_item_t result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  tracker_scoreboard sb = new();
  crt_pkg::in_item_t sent_log[$];

  command_retransmit_tracker_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .out_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // values as they stood just before the rising edge
  clocking mon_cb @(posedge clk_i);
    input rst_ni, out_valid_o, result_o;
  endclocking

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL command_retransmit_tracker_core");
    $finish;
  end

  always @(mon_cb) begin
    if (mon_cb.rst_ni && mon_cb.out_valid_o) sb.check(mon_cb.result_o);
  end

  // called right after a falling edge; returns at the falling edge after the item is taken
  task send_item(crt_pkg::in_item_t x);
    start  <= 1'b1;
    item_i <= x;
    while (busy) @(negedge clk_i);
    sb.note_item(x);
    if (x.func == crt_pkg::FUNC_SEND) begin
      sent_log.push_back(x);
      if (sent_log.size() > 32) void'(sent_log.pop_front());
    end
    @(negedge clk_i);
  endtask

  task idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task write_reg(crt_pkg::crt_reg_e idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    while (!cfg_ready_o) @(negedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task write_all(int rt, int mt, int mr, int en, int dis);
    write_reg(crt_pkg::REG_RESP_TIME, 16'(rt));
    write_reg(crt_pkg::REG_MAX_TIME, 16'(mt));
    write_reg(crt_pkg::REG_MAX_RETRY, 16'(mr));
    write_reg(crt_pkg::REG_FLOW_EN, 16'(en));
    write_reg(crt_pkg::REG_FLOW_DIS, 16'(dis));
  endtask

  function automatic crt_pkg::in_item_t make_item(crt_pkg::crt_func_e f, int p, int s, int c);
    crt_pkg::in_item_t x;
    x = '0;
    x.func = f; x.port_id = 8'(p); x.stream_num = 16'(s); x.cmd_code = 8'(c);
    x.ip_fam = 8'h04; x.seq_num = 16'(s + 1); x.qos_id = 32'(32'h10 + s);
    x.tx_id = 32'(100 + s);
    x.length_ok = 1'b1;
    return x;
  endfunction

  function automatic crt_pkg::in_item_t rand_item();
    crt_pkg::in_item_t x;
    int r;
    r = $urandom_range(0, 99);
    x.port_id    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    x.stream_num = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    x.ip_fam     = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(4, 6));
    x.seq_num    = 16'($urandom);
    x.qos_id     = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2);
    x.tx_id      = $urandom;
    x.length_ok  = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0:       x.cmd_code = 8'($urandom);
      1, 2, 3: x.cmd_code = sb.cfg.flow_disable_code;
      default: x.cmd_code = sb.cfg.flow_enable_code;
    endcase
    if (r < 40) begin
      x.func = crt_pkg::FUNC_SEND;
    end else if (r < 65) begin
      x.func = crt_pkg::FUNC_RESP;
      if (sent_log.size() != 0 && $urandom_range(0, 4) != 0) begin
        x = sent_log[$urandom_range(0, sent_log.size() - 1)];
        x.func = crt_pkg::FUNC_RESP;
        x.length_ok = ($urandom_range(0, 9) != 0);
        // occasionally break one identity field
        case ($urandom_range(0, 11))
          0: x.tx_id[$urandom_range(0, 31)] ^= 1'b1;
          1: x.seq_num ^= 16'h1;
          2: x.qos_id ^= 32'h8000_0000;
          default: ;
        endcase
      end
    end else if (r < 90) begin
      x.func = crt_pkg::FUNC_TICK;
    end else begin
      x.func = crt_pkg::FUNC_CLEAN;
    end
    return x;
  endfunction

  initial begin
    crt_pkg::in_item_t x;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part with reset register values
    send_item('0);
    x = '1; x.func = crt_pkg::FUNC_SEND; x.cmd_code = 8'h05;
    send_item(x);
    send_item(make_item(crt_pkg::FUNC_SEND, 1, 7, crt_pkg::FlowEnRst));
    x = make_item(crt_pkg::FUNC_SEND, 1, 7, crt_pkg::FlowDisRst);
    x.seq_num = 16'hFFFF; x.tx_id = '1;
    send_item(x);
    x.func = crt_pkg::FUNC_RESP; x.length_ok = 1'b0;
    send_item(x);
    x.length_ok = 1'b1; x.cmd_code = 8'h05;
    send_item(x);
    x.cmd_code = crt_pkg::FlowDisRst;
    send_item(x);
    send_item(make_item(crt_pkg::FUNC_TICK, 0, 0, 0));
    send_item(make_item(crt_pkg::FUNC_CLEAN, 9, 0, 0));
    for (int i = 0; i < crt_pkg::TableDepth; i++) begin
      send_item(make_item(crt_pkg::FUNC_SEND, i % 2, 20 + i, crt_pkg::FlowEnRst));
    end
    send_item(make_item(crt_pkg::FUNC_SEND, 2, 99, crt_pkg::FlowDisRst));
    send_item(make_item(crt_pkg::FUNC_CLEAN, 0, 0, 0));
    send_item(make_item(crt_pkg::FUNC_CLEAN, 1, 0, 0));
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_all(3, 10, 2, 1, 2);
        1: write_all(1, 1, 0, 0, 255);
        2: write_all(5000, 65535, 15, 255, 0);
        3: write_all(0, 4, 1, 255, 7);
        4: write_all(2, 3, 15, $urandom, $urandom);
        5: write_all($urandom_range(1, 8), $urandom_range(1, 20), $urandom_range(0, 15), 1, 2);
        default: write_all(1, 65535, 4, 1, 2);
      endcase
      for (int k = 0; k < 20; k++) begin
        send_item(rand_item());
        idle_gap();
      end
      drain();
    end

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS command_retransmit_tracker_core");
    end else begin
      $display("FAIL command_retransmit_tracker_core");
    end
    $finish;
  end
endmodule
